// File: rtl/ggpc_pkg.sv
// package for the go-to-goal proportional controller
// shared widths, command codes and the cordic angle table; no dependencies
package ggpc_pkg;
    localparam int POS_W        = 16;
    localparam int HEAD_W       = 15;
    localparam int SPD_W        = 18;
    localparam int DSQ_W        = 33;
    localparam int DIST_W       = 17;
    localparam int CORD_W       = 28;
    localparam int ANG_W        = 21;
    localparam int ID_BITS_DEF  = 8;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS    = 24;

    localparam logic [1:0] CMD_POSE   = 2'd0;
    localparam logic [1:0] CMD_TARGET = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [15:0] CATCH_RST = 16'd2048;
    localparam logic [15:0] LGAIN_RST = 16'd512;
    localparam logic [15:0] AGAIN_RST = 16'd1536;

    localparam logic signed [ANG_W-1:0] ANG_PI     = 21'sd205887;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 21'sd411775;

    localparam logic [1:0] REG_CATCH = 2'd0;
    localparam logic [1:0] REG_LGAIN = 2'd1;
    localparam logic [1:0] REG_AGAIN = 2'd2;

    // atan(2^-i) in q.16 radians
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            5'd0:  r = 21'sd51472;
            5'd1:  r = 21'sd30386;
            5'd2:  r = 21'sd16055;
            5'd3:  r = 21'sd8150;
            5'd4:  r = 21'sd4091;
            5'd5:  r = 21'sd2047;
            5'd6:  r = 21'sd1024;
            5'd7:  r = 21'sd512;
            5'd8:  r = 21'sd256;
            5'd9:  r = 21'sd128;
            5'd10: r = 21'sd64;
            5'd11: r = 21'sd32;
            5'd12: r = 21'sd16;
            5'd13: r = 21'sd8;
            5'd14: r = 21'sd4;
            5'd15: r = 21'sd2;
            5'd16: r = 21'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic [DSQ_W-1:0]         rem;
        logic [DIST_W-1:0]        root;
    } ggpc_cell_t;
endpackage

// File: rtl/go_to_goal_p_controller.sv
// go-to-goal proportional controller, top level
// depends on ggpc_pkg, ggpc_chain, ggpc_cell
// pose and candidate transactions are taken only in the idle state with no result pending
// a control tick runs the max(21, CORDIC_STEPS) cells of the solver chain in the run state,
// then passes through the gain multiply state and the output state
// one item at a time; synchronous active-low reset clears pose, goal and run and loads the register defaults
module go_to_goal_p_controller import ggpc_pkg::*; #(
    parameter int ID_BITS      = ID_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], pos_x[17:2], pos_y[33:18], heading[48:34], target_id[56:49]
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // linear_speed[17:0], angular_speed[35:18], caught_id[43:36]
    output logic [47:0] m_tdata,
    // caught
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NCELL = (CORDIC_STEPS > 21) ? CORDIC_STEPS : 21;
    localparam int CW = $clog2(NCELL + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    // input fields
    logic [1:0]          in_cmd;
    logic [POS_W-1:0]    in_x, in_y;
    logic [HEAD_W-1:0]   in_head;
    logic [ID_BITS-1:0]  in_id;
    assign in_cmd  = s_tdata[1:0];
    assign in_x    = s_tdata[17:2];
    assign in_y    = s_tdata[33:18];
    assign in_head = s_tdata[48:34];
    assign in_id   = ID_BITS'(s_tdata[56:49]);

    // config registers
    logic [15:0] catch_reg, lgain_reg, again_reg;
    logic        wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            catch_reg <= CATCH_RST;
            lgain_reg <= LGAIN_RST;
            again_reg <= AGAIN_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_CATCH: catch_reg <= pwdata[15:0];
                REG_LGAIN: lgain_reg <= pwdata[15:0];
                REG_AGAIN: again_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[3:2])
            REG_CATCH: prdata = {16'd0, catch_reg};
            REG_LGAIN: prdata = {16'd0, lgain_reg};
            REG_AGAIN: prdata = {16'd0, again_reg};
            default:   prdata = '0;
        endcase
    end

    // controller state
    logic [POS_W-1:0]   rx_reg, ry_reg, gx_reg, gy_reg, bx_reg, by_reg;
    logic signed [HEAD_W-1:0] rh_reg;
    logic [ID_BITS-1:0] gid_reg, bid_reg;
    logic [DSQ_W-1:0]   bdsq_reg;
    logic pose_reg, goal_reg, bfound_reg;
    logic [2:0]  st_reg;
    logic [CW-1:0] cnt_reg;

    logic take;
    assign s_tready = (st_reg == ST_IDLE) && !m_tvalid;
    assign take = s_tvalid && s_tready;

    // candidate squared distance
    logic signed [POS_W:0] cdx, cdy;
    logic signed [2*POS_W+1:0] cdx_sq, cdy_sq;
    logic [DSQ_W-1:0] cdsq;
    assign cdx    = $signed({1'b0, in_x}) - $signed({1'b0, rx_reg});
    assign cdy    = $signed({1'b0, in_y}) - $signed({1'b0, ry_reg});
    assign cdx_sq = cdx * cdx;
    assign cdy_sq = cdy * cdy;
    assign cdsq   = DSQ_W'($unsigned(cdx_sq)) + DSQ_W'($unsigned(cdy_sq));

    // tick seed for the chain
    logic signed [POS_W:0] tdx, tdy;
    logic signed [2*POS_W+1:0] tdx_sq, tdy_sq;
    ggpc_cell_t seed, res;
    logic signed [CORD_W-1:0] sx, sy;
    assign tdx    = $signed({1'b0, gx_reg}) - $signed({1'b0, rx_reg});
    assign tdy    = $signed({1'b0, gy_reg}) - $signed({1'b0, ry_reg});
    assign tdx_sq = tdx * tdx;
    assign tdy_sq = tdy * tdy;
    always_comb begin
        sx = CORD_W'(tdx) <<< 8;
        sy = CORD_W'(tdy) <<< 8;
        seed.z = '0;
        if (tdx < 0) begin
            seed.z = (tdy < 0) ? -ANG_PI : ANG_PI;
            sx = -sx;
            sy = -sy;
        end
        seed.x    = sx;
        seed.y    = sy;
        seed.rem  = DSQ_W'($unsigned(tdx_sq)) + DSQ_W'($unsigned(tdy_sq));
        seed.root = '0;
    end

    logic chain_en;
    assign chain_en = (st_reg == ST_RUN) || (st_reg == ST_IDLE);
    ggpc_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
        .aclk (aclk), .en (chain_en), .seed (seed), .result (res)
    );

    // post processing
    logic signed [ANG_W:0] err0, err;
    logic signed [ANG_W+17:0] aprod_reg, aprod_next;
    logic [DIST_W+15:0] lprod_reg, lprod_next;
    logic near_reg, near_next;
    always_comb begin
        err0 = (ANG_W+1)'(res.z) - ((ANG_W+1)'(rh_reg) <<< 4);
        err  = err0;
        if (err0 > (ANG_W+1)'(ANG_PI))       err = err0 - (ANG_W+1)'(ANG_TWO_PI);
        else if (err0 < -(ANG_W+1)'(ANG_PI)) err = err0 + (ANG_W+1)'(ANG_TWO_PI);
        aprod_next = $signed({1'b0, again_reg}) * err + (ANG_W+18)'(2048);
        lprod_next = lgain_reg * res.root + (DIST_W+16)'(128);
        near_next  = res.root <= DIST_W'(catch_reg);
    end

    logic [SPD_W-1:0] lin_sat, ang_sat;
    logic [DIST_W+7:0] lsh;
    logic signed [ANG_W+5:0] ash;
    assign lsh = lprod_reg[DIST_W+15:8];
    assign ash = aprod_reg[ANG_W+17:12];
    always_comb begin
        lin_sat = (lsh > (DIST_W+8)'(262143)) ? 18'h3FFFF : SPD_W'(lsh);
        if (ash > (ANG_W+6)'(131071))       ang_sat = 18'h1FFFF;
        else if (ash < -(ANG_W+6)'(131072)) ang_sat = 18'h20000;
        else                                ang_sat = SPD_W'(ash);
    end

    always_ff @(posedge aclk) begin
        aprod_reg <= aprod_next;
        lprod_reg <= lprod_next;
        near_reg  <= near_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; cnt_reg <= '0; m_tvalid <= 1'b0;
            pose_reg <= 1'b0; goal_reg <= 1'b0; bfound_reg <= 1'b0;
            rx_reg <= '0; ry_reg <= '0; rh_reg <= '0;
            gx_reg <= '0; gy_reg <= '0; gid_reg <= '0;
            bx_reg <= '0; by_reg <= '0; bid_reg <= '0; bdsq_reg <= '0;
            m_tdata <= '0; m_tuser <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (st_reg)
                ST_IDLE: if (take) begin
                    if (in_cmd == CMD_POSE) begin
                        rx_reg <= in_x; ry_reg <= in_y; rh_reg <= in_head;
                        pose_reg <= 1'b1;
                    end else if (in_cmd == CMD_TARGET && pose_reg) begin
                        if (!bfound_reg || cdsq < bdsq_reg) begin
                            bx_reg <= in_x; by_reg <= in_y; bid_reg <= in_id;
                            bdsq_reg <= cdsq;
                        end
                        if (s_tlast) begin
                            // commit the run's best, this entry included
                            goal_reg <= 1'b1;
                            bfound_reg <= 1'b0;
                            if (!bfound_reg || cdsq < bdsq_reg) begin
                                gx_reg <= in_x; gy_reg <= in_y; gid_reg <= in_id;
                            end else begin
                                gx_reg <= bx_reg; gy_reg <= by_reg; gid_reg <= bid_reg;
                            end
                        end else begin
                            bfound_reg <= 1'b1;
                        end
                    end else if (in_cmd == CMD_TICK && pose_reg && goal_reg) begin
                        st_reg <= ST_RUN; cnt_reg <= CW'(1);
                    end
                end
                ST_RUN: begin
                    if (cnt_reg == CW'(NCELL)) st_reg <= ST_MUL;
                    else cnt_reg <= cnt_reg + CW'(1);
                end
                ST_MUL: st_reg <= ST_OUT;
                ST_OUT: begin
                    st_reg <= ST_IDLE;
                    m_tvalid <= 1'b1;
                    if (near_reg) begin
                        m_tdata <= {4'd0, 8'(gid_reg), 18'd0, 18'd0};
                        m_tuser <= 1'b1;
                        goal_reg <= 1'b0;
                    end else begin
                        m_tdata <= {4'd0, 8'd0, ang_sat, lin_sat};
                        m_tuser <= 1'b0;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/ggpc_cell.sv
// one cell of the solver chain: a cordic vectoring step and a sqrt digit step
// depends on ggpc_pkg
module ggpc_cell import ggpc_pkg::*; #(
    parameter int STEP      = 0,
    parameter bit CORDIC_ON = 1'b1
) (
    input  logic       aclk,
    input  logic       en,
    input  ggpc_cell_t d_in,
    output ggpc_cell_t d_out
);
    localparam int SQ_SH = (STEP < 21) ? 2 * (20 - STEP) : 0;
    localparam logic [DSQ_W+8:0] SQ_BIT = (STEP < 21) ? (42'd1 << SQ_SH) : '0;

    ggpc_cell_t d_next, d_reg;
    logic [DSQ_W+8:0] trial;
    logic [DSQ_W+8:0] rem_w;
    logic [DSQ_W+8:0] root_w;

    always_comb begin
        d_next = d_in;
        if (CORDIC_ON && STEP < MAX_STEPS) begin
            if (!d_in.y[CORD_W-1]) begin
                d_next.x = d_in.x + (d_in.y >>> STEP);
                d_next.y = d_in.y - (d_in.x >>> STEP);
                d_next.z = d_in.z + atan_q16(5'(STEP));
            end else begin
                d_next.x = d_in.x - (d_in.y >>> STEP);
                d_next.y = d_in.y + (d_in.x >>> STEP);
                d_next.z = d_in.z - atan_q16(5'(STEP));
            end
        end
        // trial is (4*root + 1) scaled to this digit's weight
        rem_w  = 42'(d_in.rem);
        root_w = 42'(d_in.root) << (SQ_SH + 2);
        trial  = root_w + SQ_BIT;
        if (STEP < 21) begin
            if (rem_w >= trial) begin
                d_next.rem  = DSQ_W'(rem_w - trial);
                d_next.root = DIST_W'({d_in.root, 1'b1});
            end else begin
                d_next.root = DIST_W'({d_in.root, 1'b0});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end
    assign d_out = d_reg;
endmodule

// File: rtl/ggpc_chain.sv
// row of solver cells; cells at or past CORDIC_STEPS do only the sqrt digit step
// depends on ggpc_pkg and ggpc_cell
module ggpc_chain import ggpc_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic       aclk,
    input  logic       en,
    input  ggpc_cell_t seed,
    output ggpc_cell_t result
);
    localparam int NCELL = (CORDIC_STEPS > 21) ? CORDIC_STEPS : 21;

    ggpc_cell_t link [0:NCELL];

    assign link[0] = seed;
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        if (g < CORDIC_STEPS) begin : g_full
            ggpc_cell #(.STEP(g), .CORDIC_ON(1'b1)) u_cell (
                .aclk (aclk), .en (en), .d_in (link[g]), .d_out (link[g+1])
            );
        end else begin : g_sq
            ggpc_cell #(.STEP(g), .CORDIC_ON(1'b0)) u_cell (
                .aclk (aclk), .en (en), .d_in (link[g]), .d_out (link[g+1])
            );
        end
    end
    assign result = link[NCELL];
endmodule

// File: dv/testbench.sv
// self-checking testbench for the go-to-goal proportional controller
// depends on ggpc_pkg and go_to_goal_p_controller; drives the stream and apb ports
module testbench;
    import ggpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // register indexes in the order of the register map
    typedef enum logic [1:0] {
        IDX_CATCH = 2'd0,
        IDX_LGAIN = 2'd1,
        IDX_AGAIN = 2'd2
    } reg_idx_t;

    // one input transaction
    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] px;
        logic [15:0] py;
        logic [14:0] head;
        logic [7:0]  tid;
        logic        last;
    } item_t;

    // one motion command
    typedef struct {
        logic [17:0] lin;
        logic [17:0] ang;
        logic        caught;
        logic [7:0]  cid;
    } motion_t;

    // directed table row: an expected command is typed in only where obvious
    typedef struct {
        item_t   it;
        logic    fixed;
        motion_t want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always #5 aclk = ~aclk;

    go_to_goal_p_controller dut (.*);

    // predictor state
    logic [15:0] cfg_radius, cfg_lgain, cfg_again;
    logic [15:0] rob_x, rob_y, gl_x, gl_y, bst_x, bst_y;
    logic signed [15:0] rob_head;
    logic [7:0]  gl_id, bst_id;
    logic [32:0] bst_dsq;
    logic        pose_ok, goal_ok, bst_ok;

    motion_t expected_motion[$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      stall_long = 0;

    // atan(2^-i) in q.16, own copy for the bearing predictor
    localparam longint ATAN_TBL[24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
    localparam longint PI_Q16 = 205887;
    localparam longint TWO_PI_Q16 = 411775;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic longint shr_floor(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint isqrt(input longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 40;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint bearing_q16(input longint dx, input longint dy);
        longint x, y, z, nx;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (x < 0) begin
            z = (y < 0) ? -PI_Q16 : PI_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            if (y >= 0) begin
                nx = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z += ATAN_TBL[i];
            end else begin
                nx = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z -= ATAN_TBL[i];
            end
            x = nx;
        end
        return z;
    endfunction

    task automatic predictor_reset();
        cfg_radius = CATCH_RST;
        cfg_lgain = LGAIN_RST;
        cfg_again = AGAIN_RST;
        rob_x = 0; rob_y = 0; rob_head = 0;
        gl_x = 0; gl_y = 0; gl_id = 0;
        bst_x = 0; bst_y = 0; bst_id = 0; bst_dsq = 0;
        pose_ok = 0; goal_ok = 0; bst_ok = 0;
    endtask

    // advance the controller model by one accepted input, queue any motion command
    task automatic steer_predict(input item_t it);
        longint dx, dy, d, dist_q, lin, err, ang;
        motion_t m;
        case (it.cmd)
            CMD_POSE: begin
                rob_x = it.px;
                rob_y = it.py;
                rob_head = {it.head[14], it.head};
                pose_ok = 1;
            end
            CMD_TARGET: begin
                if (pose_ok) begin
                    dx = longint'(it.px) - longint'(rob_x);
                    dy = longint'(it.py) - longint'(rob_y);
                    d = dx * dx + dy * dy;
                    if (!bst_ok || d < longint'(bst_dsq)) begin
                        bst_x = it.px; bst_y = it.py; bst_id = it.tid;
                        bst_dsq = d[32:0]; bst_ok = 1;
                    end
                    if (it.last) begin
                        gl_x = bst_x; gl_y = bst_y; gl_id = bst_id;
                        goal_ok = 1; bst_ok = 0;
                    end
                end
            end
            CMD_TICK: begin
                if (pose_ok && goal_ok) begin
                    dx = longint'(gl_x) - longint'(rob_x);
                    dy = longint'(gl_y) - longint'(rob_y);
                    dist_q = isqrt(dx * dx + dy * dy);
                    if (dist_q > longint'(cfg_radius)) begin
                        lin = (longint'(cfg_lgain) * dist_q + 128) >> 8;
                        if (lin > 262143) lin = 262143;
                        err = bearing_q16(dx, dy) - longint'(rob_head) * 16;
                        if (err > PI_Q16) err -= TWO_PI_Q16;
                        else if (err < -PI_Q16) err += TWO_PI_Q16;
                        ang = shr_floor(longint'(cfg_again) * err + 2048, 12);
                        if (ang > 131071) ang = 131071;
                        if (ang < -131072) ang = -131072;
                        m.lin = lin[17:0];
                        m.ang = ang[17:0];
                        m.caught = 0;
                        m.cid = 0;
                    end else begin
                        m.lin = 0; m.ang = 0; m.caught = 1; m.cid = gl_id;
                        goal_ok = 0;
                    end
                    expected_motion.push_back(m);
                end
            end
            default: ;
        endcase
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (stall_long) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                stall_long = 0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
            m_tready <= (gap == 0);
            if (gap != 0) begin
                repeat (gap) @(posedge aclk);
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // compare every accepted motion command with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            motion_t w;
            if (expected_motion.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[17:0], -1);
            end else begin
                w = expected_motion.pop_front();
                if (m_tdata[17:0] !== w.lin)
                    report_mismatch("linear_speed", m_tdata[17:0], w.lin);
                if (m_tdata[35:18] !== w.ang)
                    report_mismatch("angular_speed", $signed(m_tdata[35:18]), $signed(w.ang));
                if (m_tuser !== w.caught)
                    report_mismatch("caught", m_tuser, w.caught);
                if (m_tdata[43:36] !== w.cid)
                    report_mismatch("caught_id", m_tdata[43:36], w.cid);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [15:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            IDX_CATCH: cfg_radius = val;
            IDX_LGAIN: cfg_lgain = val;
            default:   cfg_again = val;
        endcase
    endtask

    // wait for all motion commands, then the tick latency before touching registers
    task automatic drain();
        while (expected_motion.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // offer one item with a random gap, wait for its acceptance
    task automatic send_item(input item_t it, input bit no_gap);
        int gap;
        gap = no_gap ? 0 :
              (($urandom_range(0, 14) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2));
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, it.tid, it.head, it.py, it.px, it.cmd};
        s_tlast <= it.last;
        @(posedge aclk iff s_tready);
        steer_predict(it);
    endtask

    function automatic item_t mk(input logic [1:0] c, input logic [15:0] x, input logic [15:0] y,
                                 input logic [14:0] h, input logic [7:0] id, input logic l);
        item_t it;
        it.cmd = c; it.px = x; it.py = y; it.head = h; it.tid = id; it.last = l;
        return it;
    endfunction

    // mostly well-formed: pose, candidate run, a few ticks approaching
    function automatic item_t rand_item();
        item_t it;
        int r;
        r = $urandom_range(0, 19);
        it.px = (r < 3) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
        it.py = (r == 4) ? 16'hFFFF : 16'($urandom);
        it.head = 15'($urandom);
        it.tid = 8'($urandom);
        it.last = $urandom_range(0, 3) == 0;
        if (r == 19) it.cmd = 2'd3;
        else if (r < 4) it.cmd = CMD_POSE;
        else if (r < 11) it.cmd = CMD_TARGET;
        else it.cmd = CMD_TICK;
        // near-goal poses so catches happen often
        if (it.cmd == CMD_POSE && goal_ok && $urandom_range(0, 2) == 0) begin
            it.px = gl_x + 16'($signed($urandom_range(0, 2000)) - 1000);
            it.py = gl_y + 16'($signed($urandom_range(0, 2000)) - 1000);
        end
        return it;
    endfunction

    initial begin
        row_t dir[$];
        row_t rw;
        int   n;
        predictor_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        rw.fixed = 0; rw.want = '{0, 0, 0, 0};
        rw.it = mk(CMD_TICK, 0, 0, 0, 0, 0); dir.push_back(rw);            // tick with nothing
        rw.it = mk(CMD_TARGET, 100, 100, 0, 5, 1); dir.push_back(rw);      // target before pose
        rw.it = mk(CMD_TICK, 0, 0, 0, 0, 0); dir.push_back(rw);
        rw.it = mk(CMD_POSE, 0, 0, 15'h4000, 0, 0); dir.push_back(rw);     // most negative heading
        rw.it = mk(CMD_TICK, 0, 0, 0, 0, 0); dir.push_back(rw);            // pose, no goal
        rw.it = mk(CMD_TARGET, 16'hFFFF, 16'hFFFF, 0, 8'hFF, 0); dir.push_back(rw);
        rw.it = mk(CMD_TARGET, 16'hFFFF, 0, 0, 8'h11, 0); dir.push_back(rw);
        rw.it = mk(CMD_TARGET, 0, 16'hFFFF, 0, 8'h22, 1); dir.push_back(rw); // tie keeps first
        rw.it = mk(CMD_TICK, 0, 0, 0, 0, 0); dir.push_back(rw);
        rw.it = mk(CMD_POSE, 16'hFFFF, 16'hFFFF, 15'h3FFF, 0, 0); dir.push_back(rw);
        rw.it = mk(CMD_TARGET, 0, 0, 0, 8'h33, 1); dir.push_back(rw);
        rw.it = mk(CMD_TICK, 0, 0, 0, 0, 0); dir.push_back(rw);            // negative x bearing
        rw.it = mk(2'd3, 16'h1234, 0, 0, 0, 1); dir.push_back(rw);         // unknown command
        rw.it = mk(CMD_POSE, 16'h8000, 16'h8000, 0, 0, 0); dir.push_back(rw);
        rw.it = mk(CMD_TARGET, 16'h8000, 16'h8100, 0, 8'hA5, 1); dir.push_back(rw);
        rw.fixed = 1; rw.want = '{0, 0, 1, 8'hA5};                        // within radius
        rw.it = mk(CMD_TICK, 0, 0, 0, 0, 0); dir.push_back(rw);
        rw.fixed = 0;
        rw.it = mk(CMD_TICK, 0, 0, 0, 0, 0); dir.push_back(rw);            // goal cleared
        rw.it = mk(CMD_TARGET, 16'h8000, 16'h7000, 0, 8'h01, 1); dir.push_back(rw);
        rw.it = mk(CMD_TICK, 0, 0, 0, 0, 0); dir.push_back(rw);

        foreach (dir[i]) begin
            n = expected_motion.size();
            send_item(dir[i].it, 0);
            if (dir[i].fixed && expected_motion.size() == n + 1)
                expected_motion[n] = dir[i].want;
        end
        s_tvalid <= 1'b0;
        drain();

        // register extremes, then the reset defaults, then random settings; each phase of random items
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin reg_write(IDX_CATCH, 16'h0000); reg_write(IDX_LGAIN, 16'hFFFF);
                         reg_write(IDX_AGAIN, 16'hFFFF); end
                1: begin reg_write(IDX_CATCH, 16'hFFFF); reg_write(IDX_LGAIN, 16'h0000);
                         reg_write(IDX_AGAIN, 16'h0000); end
                2: begin reg_write(IDX_CATCH, CATCH_RST); reg_write(IDX_LGAIN, LGAIN_RST);
                         reg_write(IDX_AGAIN, AGAIN_RST); end
                default: begin reg_write(IDX_CATCH, 16'($urandom_range(0, 8192)));
                         reg_write(IDX_LGAIN, 16'($urandom));
                         reg_write(IDX_AGAIN, 16'($urandom)); end
            endcase
            if (ph == 2) stall_long = 1;
            for (int k = 0; k < 130; k++)
                send_item(rand_item(), ph == 2 && k < 60);
            s_tvalid <= 1'b0;
            drain();
        end

        if (errors == 0 && expected_motion.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/ggpc_pkg.sv
rtl/ggpc_cell.sv
rtl/ggpc_chain.sv
rtl/go_to_goal_p_controller.sv
dv/testbench.sv
